/* rtl/three_class_priority_queue_assert.svh */
// Assertion macros for the three-class priority queue.
// Both forms expect aclk and aresetn in scope.
`ifndef THREE_CLASS_PRIORITY_QUEUE_ASSERT_SVH
`define THREE_CLASS_PRIORITY_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TCPQ_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tcpq assertion failed");
`define TCPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tcpq assertion failed");
`else
`define TCPQ_ASSERT_SAME(lbl, ante, cons)
`define TCPQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/tcpq_pkg.sv */
package tcpq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int NUM_CLASS     = 3;
    localparam int ID_W          = 16;
    localparam int CLASS_W       = 2;
    localparam int STATUS_W      = 2;
    localparam int QIDX_W        = 2;

    localparam logic [CLASS_W-1:0] CLASS_HI  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_MID = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;

    localparam logic [QIDX_W-1:0] Q_HI  = 2'd0;
    localparam logic [QIDX_W-1:0] Q_MID = 2'd1;
    localparam logic [QIDX_W-1:0] Q_LO  = 2'd2;

    typedef enum logic {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ENQUEUED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_DEQUEUED = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    typedef struct packed {
        logic take;
        logic deq_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic out_valid;
    } dp_stat_t;

endpackage

/* rtl/tcpq_ctrl.sv */
module tcpq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_func,
    output logic                 s_ready,
    input  tcpq_pkg::dp_stat_t   stat,
    output tcpq_pkg::ctrl_cmd_t  cmd
);

    tcpq_pkg::state_t state_reg;
    tcpq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcpq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.take     = 1'b0;
        cmd.deq_load = 1'b0;
        case (state_reg)
            tcpq_pkg::S_IDLE: begin
                s_ready  = stat.out_free;
                cmd.take = s_valid && stat.out_free;
                // dequeue waits in S_READ for the registered store read
                if (cmd.take && (s_func == tcpq_pkg::FUNC_DEQ)) begin
                    state_next = tcpq_pkg::S_READ;
                end
            end
            tcpq_pkg::S_READ: begin
                cmd.deq_load = stat.out_free;
                if (stat.out_free) begin
                    state_next = tcpq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tcpq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/tcpq_dp.sv */
module tcpq_dp #(
    parameter int DEPTH = tcpq_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tcpq_pkg::ctrl_cmd_t           cmd,
    output tcpq_pkg::dp_stat_t            stat,
    input  logic                          s_func,
    input  logic [tcpq_pkg::CLASS_W-1:0]  s_item_class,
    input  logic [tcpq_pkg::ID_W-1:0]     s_item_id,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tcpq_pkg::STATUS_W-1:0] m_status,
    output logic [tcpq_pkg::ID_W-1:0]     m_out_id,
    output logic [tcpq_pkg::CLASS_W-1:0]  m_out_class
);

    localparam int NQ     = tcpq_pkg::NUM_CLASS;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int MEM_N  = NQ * DEPTH;
    localparam int ADDR_W = $clog2(MEM_N);
    localparam int QW     = tcpq_pkg::QIDX_W;

    logic [tcpq_pkg::ID_W-1:0] mem [MEM_N];

    logic [PTR_W-1:0] rd_ptr_reg [NQ];
    logic [PTR_W-1:0] rd_ptr_next [NQ];
    logic [PTR_W-1:0] wr_ptr_reg [NQ];
    logic [PTR_W-1:0] wr_ptr_next [NQ];
    logic [CNT_W-1:0] count_reg [NQ];
    logic [CNT_W-1:0] count_next [NQ];

    logic [tcpq_pkg::ID_W-1:0]    rdata_reg;
    logic                         deq_empty_reg;
    logic [tcpq_pkg::CLASS_W-1:0] deq_class_reg;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [tcpq_pkg::STATUS_W-1:0] m_status_reg;
    logic [tcpq_pkg::STATUS_W-1:0] m_status_next;
    logic [tcpq_pkg::ID_W-1:0]     m_out_id_reg;
    logic [tcpq_pkg::ID_W-1:0]     m_out_id_next;
    logic [tcpq_pkg::CLASS_W-1:0]  m_out_class_reg;
    logic [tcpq_pkg::CLASS_W-1:0]  m_out_class_next;

    logic            is_enq;
    logic [QW-1:0]   enq_q;
    logic [QW-1:0]   deq_q;
    logic            deq_found;
    logic [QW-1:0]   sel_q;
    logic            enq_full;
    logic [PTR_W-1:0] sel_ptr;
    logic [PTR_W-1:0] sel_ptr_inc;
    logic [ADDR_W-1:0] addr;
    logic            do_write;
    logic            do_read;

    assign is_enq = (s_func == tcpq_pkg::FUNC_ENQ);

    // any class code other than 1 or 2 is a normal item
    always_comb begin
        if (s_item_class == tcpq_pkg::CLASS_HI) begin
            enq_q = tcpq_pkg::Q_HI;
        end else if (s_item_class == tcpq_pkg::CLASS_MID) begin
            enq_q = tcpq_pkg::Q_MID;
        end else begin
            enq_q = tcpq_pkg::Q_LO;
        end
    end

    always_comb begin
        deq_found = 1'b1;
        if (count_reg[tcpq_pkg::Q_HI] != '0) begin
            deq_q = tcpq_pkg::Q_HI;
        end else if (count_reg[tcpq_pkg::Q_MID] != '0) begin
            deq_q = tcpq_pkg::Q_MID;
        end else begin
            deq_q     = tcpq_pkg::Q_LO;
            deq_found = (count_reg[tcpq_pkg::Q_LO] != '0);
        end
    end

    assign sel_q       = is_enq ? enq_q : deq_q;
    assign enq_full    = (count_reg[enq_q] == CNT_W'(DEPTH));
    assign sel_ptr     = is_enq ? wr_ptr_reg[sel_q] : rd_ptr_reg[sel_q];
    assign sel_ptr_inc = (sel_ptr == PTR_W'(DEPTH - 1)) ? '0 : sel_ptr + 1'b1;

    always_comb begin
        case (sel_q)
            tcpq_pkg::Q_HI:  addr = ADDR_W'(sel_ptr);
            tcpq_pkg::Q_MID: addr = ADDR_W'(DEPTH) + ADDR_W'(sel_ptr);
            default:         addr = ADDR_W'(2 * DEPTH) + ADDR_W'(sel_ptr);
        endcase
    end

    assign do_write = cmd.take && is_enq && !enq_full;
    assign do_read  = cmd.take && !is_enq && deq_found;

    always_comb begin
        for (int i = 0; i < NQ; i++) begin
            rd_ptr_next[i] = rd_ptr_reg[i];
            wr_ptr_next[i] = wr_ptr_reg[i];
            count_next[i]  = count_reg[i];
        end
        if (do_write) begin
            wr_ptr_next[sel_q] = sel_ptr_inc;
            count_next[sel_q]  = count_reg[sel_q] + 1'b1;
        end
        if (do_read) begin
            rd_ptr_next[sel_q] = sel_ptr_inc;
            count_next[sel_q]  = count_reg[sel_q] - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NQ; i++) begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
        end else begin
            for (int i = 0; i < NQ; i++) begin
                rd_ptr_reg[i] <= rd_ptr_next[i];
                wr_ptr_reg[i] <= wr_ptr_next[i];
                count_reg[i]  <= count_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[addr] <= s_item_id;
        end
        if (do_read) begin
            rdata_reg <= mem[addr];
        end
    end

    // remember the dequeue outcome until the read data lands
    always_ff @(posedge aclk) begin
        if (cmd.take && !is_enq) begin
            deq_empty_reg <= !deq_found;
            deq_class_reg <= tcpq_pkg::CLASS_W'(deq_q) + 1'b1;
        end
    end

    always_comb begin
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_out_id_next    = m_out_id_reg;
        m_out_class_next = m_out_class_reg;
        if (cmd.take && is_enq) begin
            m_valid_next     = 1'b1;
            m_status_next    = enq_full ? tcpq_pkg::STAT_FULL : tcpq_pkg::STAT_ENQUEUED;
            m_out_id_next    = '0;
            m_out_class_next = tcpq_pkg::CLASS_NONE;
        end else if (cmd.deq_load) begin
            m_valid_next = 1'b1;
            if (deq_empty_reg) begin
                m_status_next    = tcpq_pkg::STAT_EMPTY;
                m_out_id_next    = '0;
                m_out_class_next = tcpq_pkg::CLASS_NONE;
            end else begin
                m_status_next    = tcpq_pkg::STAT_DEQUEUED;
                m_out_id_next    = rdata_reg;
                m_out_class_next = deq_class_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg    <= m_status_next;
        m_out_id_reg    <= m_out_id_next;
        m_out_class_reg <= m_out_class_next;
    end

    assign stat.out_free  = !m_valid_reg || m_ready;
    assign stat.out_valid = m_valid_reg;

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_out_id    = m_out_id_reg;
    assign m_out_class = m_out_class_reg;

endmodule

/* rtl/three_class_priority_queue.sv */
// Channel | Handshake        | Beat contents
// input   | s_valid, s_ready | s_func, s_item_class, s_item_id
// result  | m_valid, m_ready | m_status, m_out_id, m_out_class
//
// Enqueue: result valid in the cycle after the input beat. Dequeue: the result
// passes the registered read of the class store and S_READ, then the result register.
// One item in flight; a new beat is taken once the result register is free
// or being drained in that cycle. A stalled result holds the block.
// Reset clears pointers and counts at once; no clearing pass on the store.
module three_class_priority_queue #(
    parameter int DEPTH = tcpq_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [tcpq_pkg::CLASS_W-1:0]  s_item_class,
    input  logic [tcpq_pkg::ID_W-1:0]     s_item_id,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tcpq_pkg::STATUS_W-1:0] m_status,
    output logic [tcpq_pkg::ID_W-1:0]     m_out_id,
    output logic [tcpq_pkg::CLASS_W-1:0]  m_out_class
);

    tcpq_pkg::ctrl_cmd_t cmd;
    tcpq_pkg::dp_stat_t  stat;

    tcpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tcpq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_func       (s_func),
        .s_item_class (s_item_class),
        .s_item_id    (s_item_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_out_id     (m_out_id),
        .m_out_class  (m_out_class)
    );

`include "three_class_priority_queue_assert.svh"

    `TCPQ_ASSERT_SAME(a_take_needs_room, s_valid && s_ready, !stat.out_valid || m_ready)
    `TCPQ_ASSERT_NEXT(a_enq_result_next, s_valid && s_ready && (s_func == tcpq_pkg::FUNC_ENQ), m_valid)
    `TCPQ_ASSERT_NEXT(a_deq_no_ready, s_valid && s_ready && (s_func == tcpq_pkg::FUNC_DEQ), !s_ready)
    `TCPQ_ASSERT_SAME(a_deq_has_class, m_valid && (m_status == tcpq_pkg::STAT_DEQUEUED), m_out_class != tcpq_pkg::CLASS_NONE)
    `TCPQ_ASSERT_SAME(a_other_zero, m_valid && (m_status != tcpq_pkg::STAT_DEQUEUED), (m_out_id == '0) && (m_out_class == tcpq_pkg::CLASS_NONE))

endmodule

/* test/three_class_priority_queue_tb.sv */
module three_class_priority_queue_tb;

    localparam int DEPTH        = tcpq_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 650;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [tcpq_pkg::CLASS_W-1:0] CLASS_LO = 2'd3;

    typedef struct packed {
        tcpq_pkg::status_t            status;
        logic [tcpq_pkg::ID_W-1:0]    id;
        logic [tcpq_pkg::CLASS_W-1:0] cls;
    } result_t;

    typedef struct {
        tcpq_pkg::func_t              func;
        logic [tcpq_pkg::CLASS_W-1:0] cls;
        logic [tcpq_pkg::ID_W-1:0]    id;
        int                           reps;
        bit                           typed;
        result_t                      res;
    } row_t;

    logic                          aclk         = 1'b0;
    logic                          aresetn      = 1'b0;
    logic                          s_valid      = 1'b0;
    logic                          s_ready;
    logic                          s_func       = tcpq_pkg::FUNC_ENQ;
    logic [tcpq_pkg::CLASS_W-1:0]  s_item_class = tcpq_pkg::CLASS_NONE;
    logic [tcpq_pkg::ID_W-1:0]     s_item_id    = '0;
    logic                          m_valid;
    logic                          m_ready      = 1'b0;
    logic [tcpq_pkg::STATUS_W-1:0] m_status;
    logic [tcpq_pkg::ID_W-1:0]     m_out_id;
    logic [tcpq_pkg::CLASS_W-1:0]  m_out_class;

    int cycle_count = 0;
    int mismatches  = 0;
    int tx_idle_pct = 14;
    int rx_idle_pct = 75;

    // per-class contents as the queue should hold them, oldest first
    logic [tcpq_pkg::ID_W-1:0] hi_ids[$];
    logic [tcpq_pkg::ID_W-1:0] mid_ids[$];
    logic [tcpq_pkg::ID_W-1:0] lo_ids[$];

    result_t pending_results[$];
    row_t    dir_rows[$];

    three_class_priority_queue #(
        .DEPTH(DEPTH)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_item_class(s_item_class),
        .s_item_id   (s_item_id),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_id    (m_out_id),
        .m_out_class (m_out_class)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic result_t next_queue_result(tcpq_pkg::func_t f,
                                                  logic [tcpq_pkg::CLASS_W-1:0] c,
                                                  logic [tcpq_pkg::ID_W-1:0] id);
        result_t r;
        r = '{tcpq_pkg::STAT_ENQUEUED, '0, tcpq_pkg::CLASS_NONE};
        if (f == tcpq_pkg::FUNC_ENQ) begin
            if (c == tcpq_pkg::CLASS_HI) begin
                if (hi_ids.size() >= DEPTH) r.status = tcpq_pkg::STAT_FULL;
                else hi_ids.push_back(id);
            end else if (c == tcpq_pkg::CLASS_MID) begin
                if (mid_ids.size() >= DEPTH) r.status = tcpq_pkg::STAT_FULL;
                else mid_ids.push_back(id);
            end else begin
                // class 0 lands here too
                if (lo_ids.size() >= DEPTH) r.status = tcpq_pkg::STAT_FULL;
                else lo_ids.push_back(id);
            end
        end else if (hi_ids.size() != 0) begin
            r.status = tcpq_pkg::STAT_DEQUEUED;
            r.id     = hi_ids.pop_front();
            r.cls    = tcpq_pkg::CLASS_HI;
        end else if (mid_ids.size() != 0) begin
            r.status = tcpq_pkg::STAT_DEQUEUED;
            r.id     = mid_ids.pop_front();
            r.cls    = tcpq_pkg::CLASS_MID;
        end else if (lo_ids.size() != 0) begin
            r.status = tcpq_pkg::STAT_DEQUEUED;
            r.id     = lo_ids.pop_front();
            r.cls    = CLASS_LO;
        end else begin
            r.status = tcpq_pkg::STAT_EMPTY;
        end
        return r;
    endfunction

    // Leaves s_valid high on return; an idle gap at the next beat or hold_until_drained lowers it.
    task automatic send_beat(tcpq_pkg::func_t f, logic [tcpq_pkg::CLASS_W-1:0] c,
                             logic [tcpq_pkg::ID_W-1:0] id,
                             bit typed, result_t typed_res);
        result_t predicted;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid      <= 1'b1;
        s_func       <= f;
        s_item_class <= c;
        s_item_id    <= id;
        do @(posedge aclk); while (!s_ready);
        predicted = next_queue_result(f, c, id);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic add_row(tcpq_pkg::func_t f, logic [tcpq_pkg::CLASS_W-1:0] c,
                           logic [tcpq_pkg::ID_W-1:0] id, int reps,
                           bit typed, tcpq_pkg::status_t st,
                           logic [tcpq_pkg::ID_W-1:0] oid,
                           logic [tcpq_pkg::CLASS_W-1:0] ocls);
        row_t r;
        r.func  = f;
        r.cls   = c;
        r.id    = id;
        r.reps  = reps;
        r.typed = typed;
        r.res   = '{st, oid, ocls};
        dir_rows.push_back(r);
    endtask

    // Bursts lean toward enqueue, dequeue or neither, and toward one class,
    // so single classes run full and the whole queue runs dry.
    task automatic send_random(int n_items);
        int                           sent;
        int                           burst_len;
        int                           enq_pct;
        int                           lean;
        logic [tcpq_pkg::CLASS_W-1:0] favored;
        logic [tcpq_pkg::CLASS_W-1:0] c;
        tcpq_pkg::func_t              f;
        sent = 0;
        while (sent < n_items) begin
            lean      = $urandom_range(2);
            enq_pct   = (lean == 0) ? 85 : (lean == 1) ? 15 : 50;
            favored   = tcpq_pkg::CLASS_W'($urandom_range(1, 3));
            burst_len = $urandom_range(4, 40);
            for (int k = 0; k < burst_len && sent < n_items; k++) begin
                f = ($urandom_range(99) < enq_pct) ? tcpq_pkg::FUNC_ENQ : tcpq_pkg::FUNC_DEQ;
                c = ($urandom_range(99) < 70) ? favored
                                              : tcpq_pkg::CLASS_W'($urandom_range(3));
                send_beat(f, c, tcpq_pkg::ID_W'($urandom), 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected beat: status %0d id %h class %0d",
                                          m_status, m_out_id, m_out_class));
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status || m_out_id !== want.id ||
                    m_out_class !== want.cls) begin
                    report_mismatch($sformatf(
                        "got status %0d id %h class %0d, want status %0d id %h class %0d",
                        m_status, m_out_id, m_out_class, want.status, want.id, want.cls));
                end
            end
        end
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        add_row(tcpq_pkg::FUNC_DEQ, CLASS_LO, 16'hFFFF, 1, 1'b1,
                tcpq_pkg::STAT_EMPTY, 16'h0000, tcpq_pkg::CLASS_NONE);
        add_row(tcpq_pkg::FUNC_ENQ, CLASS_LO, 16'hFFFF, 1, 1'b1,
                tcpq_pkg::STAT_ENQUEUED, 16'h0000, tcpq_pkg::CLASS_NONE);
        add_row(tcpq_pkg::FUNC_ENQ, tcpq_pkg::CLASS_NONE, 16'h0000, 1, 1'b1,
                tcpq_pkg::STAT_ENQUEUED, 16'h0000, tcpq_pkg::CLASS_NONE);
        add_row(tcpq_pkg::FUNC_ENQ, tcpq_pkg::CLASS_HI, 16'h8001, 1, 1'b1,
                tcpq_pkg::STAT_ENQUEUED, 16'h0000, tcpq_pkg::CLASS_NONE);
        add_row(tcpq_pkg::FUNC_ENQ, tcpq_pkg::CLASS_MID, 16'h1234, 1, 1'b1,
                tcpq_pkg::STAT_ENQUEUED, 16'h0000, tcpq_pkg::CLASS_NONE);
        add_row(tcpq_pkg::FUNC_ENQ, tcpq_pkg::CLASS_HI, 16'h0000, 1, 1'b1,
                tcpq_pkg::STAT_ENQUEUED, 16'h0000, tcpq_pkg::CLASS_NONE);
        // dequeue payload fields are don't-care; drive them busy
        add_row(tcpq_pkg::FUNC_DEQ, CLASS_LO, 16'hFFFF, 1, 1'b1,
                tcpq_pkg::STAT_DEQUEUED, 16'h8001, tcpq_pkg::CLASS_HI);
        add_row(tcpq_pkg::FUNC_DEQ, tcpq_pkg::CLASS_MID, 16'h5555, 1, 1'b1,
                tcpq_pkg::STAT_DEQUEUED, 16'h0000, tcpq_pkg::CLASS_HI);
        add_row(tcpq_pkg::FUNC_DEQ, tcpq_pkg::CLASS_NONE, 16'hAAAA, 1, 1'b1,
                tcpq_pkg::STAT_DEQUEUED, 16'h1234, tcpq_pkg::CLASS_MID);
        add_row(tcpq_pkg::FUNC_DEQ, tcpq_pkg::CLASS_HI, 16'h0000, 1, 1'b1,
                tcpq_pkg::STAT_DEQUEUED, 16'hFFFF, CLASS_LO);
        add_row(tcpq_pkg::FUNC_DEQ, CLASS_LO, 16'h7FFF, 1, 1'b1,
                tcpq_pkg::STAT_DEQUEUED, 16'h0000, CLASS_LO);
        add_row(tcpq_pkg::FUNC_DEQ, CLASS_LO, 16'hFFFF, 1, 1'b1,
                tcpq_pkg::STAT_EMPTY, 16'h0000, tcpq_pkg::CLASS_NONE);
        add_row(tcpq_pkg::FUNC_ENQ, tcpq_pkg::CLASS_MID, 16'hA500, DEPTH, 1'b1,
                tcpq_pkg::STAT_ENQUEUED, 16'h0000, tcpq_pkg::CLASS_NONE);
        add_row(tcpq_pkg::FUNC_ENQ, tcpq_pkg::CLASS_MID, 16'h5A5A, 1, 1'b1,
                tcpq_pkg::STAT_FULL, 16'h0000, tcpq_pkg::CLASS_NONE);
        add_row(tcpq_pkg::FUNC_ENQ, CLASS_LO, 16'h7777, 1, 1'b0,
                tcpq_pkg::STAT_ENQUEUED, 16'h0000, tcpq_pkg::CLASS_NONE);
        add_row(tcpq_pkg::FUNC_ENQ, tcpq_pkg::CLASS_HI, 16'hFFFF, 1, 1'b0,
                tcpq_pkg::STAT_ENQUEUED, 16'h0000, tcpq_pkg::CLASS_NONE);
        add_row(tcpq_pkg::FUNC_DEQ, tcpq_pkg::CLASS_NONE, 16'h0000, 1, 1'b1,
                tcpq_pkg::STAT_DEQUEUED, 16'hFFFF, tcpq_pkg::CLASS_HI);
        add_row(tcpq_pkg::FUNC_DEQ, tcpq_pkg::CLASS_NONE, 16'h0000, 1, 1'b1,
                tcpq_pkg::STAT_DEQUEUED, 16'hA500, tcpq_pkg::CLASS_MID);
        // drains the rest of class 2, the class 3 item, then one empty
        add_row(tcpq_pkg::FUNC_DEQ, tcpq_pkg::CLASS_HI, 16'h0F0F, DEPTH + 1, 1'b0,
                tcpq_pkg::STAT_EMPTY, 16'h0000, tcpq_pkg::CLASS_NONE);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            for (int k = 0; k < dir_rows[i].reps; k++) begin
                send_beat(dir_rows[i].func, dir_rows[i].cls,
                          dir_rows[i].id + tcpq_pkg::ID_W'(k),
                          dir_rows[i].typed, dir_rows[i].res);
            end
        end
        hold_until_drained();

        send_random(RANDOM_ITEMS / 3);
        hold_until_drained();

        tx_idle_pct = 75;
        rx_idle_pct = 14;
        send_random(RANDOM_ITEMS / 3);
        hold_until_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        hold_until_drained();

        // catch any stray beat after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* three_class_priority_queue.f */
+incdir+rtl
rtl/tcpq_pkg.sv
rtl/tcpq_ctrl.sv
rtl/tcpq_dp.sv
rtl/three_class_priority_queue.sv
test/three_class_priority_queue_tb.sv
